@@ rtl/delta_copy_literal_counter_defines.svh @@
// Assertion macros for the delta_copy_literal_counter checker.
// No dependencies; include by bare file name.
`ifndef DELTA_COPY_LITERAL_COUNTER_DEFINES_SVH
`define DELTA_COPY_LITERAL_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DCLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DCLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dclc_pkg.sv @@
// Shared types and constants for the delta stream counter.
// No dependencies; used by the top level and its checker.
package dclc_pkg;

  localparam int unsigned MIN_DELTA_BYTES = 4;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned OUT_CNT_W       = 33;
  localparam int unsigned BCNT_W          = 3;
  localparam int unsigned COPY_SIZE_W     = 17;

  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [OUT_CNT_W-1:0]   out_count_t;
  typedef logic [BCNT_W-1:0]      byte_count_t;
  typedef logic [COPY_SIZE_W-1:0] copy_size_t;

  localparam byte_count_t BYTE_COUNT_MAX = '1;
  localparam copy_size_t  COPY_ZERO_SIZE = 17'h10000;
  localparam out_count_t  OUT_COUNT_MAX  = '1;
  localparam count_t      COUNT_MAX      = '1;

endpackage

@@ rtl/delta_copy_literal_counter.sv @@
// Delta stream counter: header decode, command parse, saturating counts.
// Uses dclc_pkg for widths, limits and count types.
// A result is registered and appears in the cycle after its final byte is accepted.
// Throughput: one byte per cycle; the per-byte state update is one register pass.
// Input stalls only when a final byte arrives while a held result is stalled.
// Sync reset (rst_n low) returns to the source header, clears counts and out_valid.
module delta_copy_literal_counter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_status,
  output dclc_pkg::count_t out_source_copied,
  output dclc_pkg::count_t out_literal_bytes
);
  import dclc_pkg::*;

  typedef enum logic [2:0] {
    PH_SRC = 3'd0,
    PH_DST = 3'd1,
    PH_CMD = 3'd2,
    PH_ARG = 3'd3,
    PH_LIT = 3'd4,
    PH_ERR = 3'd5
  } phase_t;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  shift_pos_r, shift_pos_nxt;
  count_t      dest_size_r, dest_size_nxt;
  logic [5:0]  arg_flags_r, arg_flags_nxt;
  copy_size_t  copy_acc_r, copy_acc_nxt;
  logic        from_dest_r, from_dest_nxt;
  logic [6:0]  lit_rem_r, lit_rem_nxt;
  count_t      copied_r, copied_nxt;
  count_t      added_r, added_nxt;
  out_count_t  out_cnt_r, out_cnt_nxt;
  byte_count_t byte_cnt_r, byte_cnt_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_status_r;
  count_t      out_copied_r;
  count_t      out_added_r;

  logic        in_accept;
  logic        load_result;
  logic        bad;

  // Scratch for the command decode
  logic [5:0]  header_sh;
  logic [38:0] header_part;
  logic [5:0]  arg_low_bit;
  logic [5:0]  arg_flags_left;
  logic        finish;
  logic        finish_from_dest;
  copy_size_t  finish_acc;
  copy_size_t  copy_size;
  logic        lit_en;
  logic [33:0] out_sum;
  logic [32:0] copied_sum;
  logic [32:0] added_sum;
  copy_size_t  out_amt;

  // Hold a final byte only when the held result cannot move; every other
  // request goes straight into the parser state.
  assign in_stall    = out_valid_r & out_stall & in_last_byte;
  assign in_accept   = in_valid & ~in_stall;
  assign load_result = in_accept & in_last_byte;

  always_comb begin
    phase_nxt     = phase_r;
    shift_pos_nxt = shift_pos_r;
    dest_size_nxt = dest_size_r;
    arg_flags_nxt = arg_flags_r;
    copy_acc_nxt  = copy_acc_r;
    from_dest_nxt = from_dest_r;
    lit_rem_nxt   = lit_rem_r;
    copied_nxt    = copied_r;
    added_nxt     = added_r;
    out_cnt_nxt   = out_cnt_r;
    byte_cnt_nxt  = (byte_cnt_r == BYTE_COUNT_MAX) ? byte_cnt_r : byte_cnt_r + 3'd1;

    header_sh        = 6'(shift_pos_r) * 6'd7;
    header_part      = 39'(in_data_byte[6:0]) << header_sh;
    arg_low_bit      = arg_flags_r & (~arg_flags_r + 6'd1);
    arg_flags_left   = arg_flags_r & ~arg_low_bit;
    finish           = 1'b0;
    finish_from_dest = from_dest_r;
    finish_acc       = copy_acc_r;
    lit_en           = 1'b0;

    unique case (phase_r) inside
      PH_SRC, PH_DST: begin
        // Long header or a destination size beyond 32 bits: park in error.
        if (phase_r == PH_DST && shift_pos_r >= 3'd4 && in_data_byte[6:4] != 3'd0) begin
          phase_nxt = PH_ERR;
        end else begin
          if (phase_r == PH_DST) begin
            dest_size_nxt = dest_size_r | header_part[31:0];
          end
          if (in_data_byte[7]) begin
            if (shift_pos_r >= 3'd4) phase_nxt = PH_ERR;
            else                     shift_pos_nxt = shift_pos_r + 3'd1;
          end else begin
            shift_pos_nxt = '0;
            phase_nxt     = (phase_r == PH_DST) ? PH_CMD : PH_DST;
          end
        end
      end
      PH_CMD: begin
        if (in_data_byte[7]) begin
          arg_flags_nxt    = in_data_byte[5:0];
          from_dest_nxt    = in_data_byte[6];
          copy_acc_nxt     = '0;
          finish_from_dest = in_data_byte[6];
          finish_acc       = '0;
          if (in_data_byte[5:0] == 6'd0) finish = 1'b1;
          else                           phase_nxt = PH_ARG;
        end else begin
          lit_en      = 1'b1;
          lit_rem_nxt = in_data_byte[6:0];
          if (in_data_byte[6:0] != 7'd0) phase_nxt = PH_LIT;
        end
      end
      PH_ARG: begin
        // Offset bytes are dropped; only the two size bytes land.
        finish_acc = copy_acc_r;
        if (arg_low_bit == 6'b01_0000) finish_acc = copy_acc_r | 17'(in_data_byte);
        if (arg_low_bit == 6'b10_0000) finish_acc = copy_acc_r | {1'b0, in_data_byte, 8'd0};
        copy_acc_nxt  = finish_acc;
        arg_flags_nxt = arg_flags_left;
        if (arg_flags_left == 6'd0) finish = 1'b1;
      end
      PH_LIT: begin
        if (lit_rem_r != 7'd0) lit_rem_nxt = lit_rem_r - 7'd1;
        if (lit_rem_r <= 7'd1) phase_nxt = PH_CMD;
      end
      default: phase_nxt = PH_ERR;
    endcase

    // Copy close-out: zero size stands for 64 KiB.
    copy_size = (finish_acc == '0) ? COPY_ZERO_SIZE : finish_acc;
    if (finish) begin
      copy_acc_nxt  = '0;
      from_dest_nxt = 1'b0;
      arg_flags_nxt = '0;
      phase_nxt     = PH_CMD;
    end

    copied_sum = {1'b0, copied_r} + 33'(copy_size);
    if (finish && !finish_from_dest) begin
      copied_nxt = copied_sum[32] ? COUNT_MAX : copied_sum[31:0];
    end
    added_sum = {1'b0, added_r} + 33'(in_data_byte);
    if (lit_en) begin
      added_nxt = added_sum[32] ? COUNT_MAX : added_sum[31:0];
    end

    // One shared adder for the output length: copy size or literal length.
    out_amt = lit_en ? 17'(in_data_byte) : copy_size;
    out_sum = {1'b0, out_cnt_r} + 34'(out_amt);
    if (finish || lit_en) begin
      out_cnt_nxt = out_sum[33] ? OUT_COUNT_MAX : out_sum[32:0];
    end

    bad = (phase_nxt != PH_CMD) ||
          (byte_cnt_nxt < BCNT_W'(MIN_DELTA_BYTES)) ||
          (out_cnt_nxt != {1'b0, dest_size_nxt});

    out_valid_nxt = load_result | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SRC;
      shift_pos_r <= '0;
      dest_size_r <= '0;
      arg_flags_r <= '0;
      copy_acc_r  <= '0;
      from_dest_r <= 1'b0;
      lit_rem_r   <= '0;
      copied_r    <= '0;
      added_r     <= '0;
      out_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load_result) begin
        // Stream done: drop all parser state and start over.
        phase_r     <= PH_SRC;
        shift_pos_r <= '0;
        dest_size_r <= '0;
        arg_flags_r <= '0;
        copy_acc_r  <= '0;
        from_dest_r <= 1'b0;
        lit_rem_r   <= '0;
        copied_r    <= '0;
        added_r     <= '0;
        out_cnt_r   <= '0;
        byte_cnt_r  <= '0;
      end else if (in_accept) begin
        phase_r     <= phase_nxt;
        shift_pos_r <= shift_pos_nxt;
        dest_size_r <= dest_size_nxt;
        arg_flags_r <= arg_flags_nxt;
        copy_acc_r  <= copy_acc_nxt;
        from_dest_r <= from_dest_nxt;
        lit_rem_r   <= lit_rem_nxt;
        copied_r    <= copied_nxt;
        added_r     <= added_nxt;
        out_cnt_r   <= out_cnt_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
      end
    end
  end

  // Result payload: no reset needed, qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (load_result) begin
      out_status_r <= bad;
      out_copied_r <= bad ? '0 : copied_nxt;
      out_added_r  <= bad ? '0 : added_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_source_copied = out_copied_r;
  assign out_literal_bytes = out_added_r;

endmodule

@@ rtl/dclc_checker.sv @@
// Port-level checker for delta_copy_literal_counter, attached by bind.
// Uses dclc_pkg and the macros in delta_copy_literal_counter_defines.svh.
`include "delta_copy_literal_counter_defines.svh"

module dclc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_last_byte,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_status,
  input dclc_pkg::count_t out_source_copied,
  input dclc_pkg::count_t out_literal_bytes
);
  import dclc_pkg::*;

  logic last_req;
  logic in_req;

  assign in_req   = in_valid & ~in_stall;
  assign last_req = in_req & in_last_byte;

  // A held result survives a stall unchanged.
  `DCLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_source_copied) && $stable(out_literal_bytes), "result changed under stall")

  // An error result carries zero counts.
  `DCLC_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_status, out_source_copied == '0 && out_literal_bytes == '0, "error result with nonzero counts")

  // A result shows up only after a final-byte request.
  `DCLC_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(out_valid), $past(last_req), "result without final byte")

  // A final byte never overruns a stalled result.
  `DCLC_ASSERT_NOW(a_no_overrun, clk, rst_n, in_valid && in_last_byte && out_valid && out_stall, in_stall, "final byte taken over stalled result")

  // Non-final bytes keep flowing.
  `DCLC_ASSERT_NOW(a_no_idle_stall, clk, rst_n, in_valid && !in_last_byte, !in_stall, "stall on non-final byte")

endmodule

bind delta_copy_literal_counter dclc_checker u_dclc_checker (.*);

@@ test/delta_copy_literal_counter_tb.sv @@
// Testbench for delta_copy_literal_counter: feeds delta streams byte by byte and
// checks status and copy/literal tallies against an in-bench stream parser.
// Depends on dclc_pkg and the delta_copy_literal_counter RTL.
module delta_copy_literal_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dclc_pkg::*;

  // Parser phases, in the order a well-formed stream walks them.
  typedef enum logic [2:0] {
    PH_SOURCE_HDR,
    PH_DEST_HDR,
    PH_COMMAND,
    PH_COPY_ARGS,
    PH_LITERAL,
    PH_BROKEN
  } phase_t;

  localparam logic [7:0] CONT_BIT      = 8'h80;  // header: another size byte follows
  localparam logic [7:0] COPY_BIT      = 8'h80;  // command: copy, else literal
  localparam logic [7:0] FROM_DEST_BIT = 8'h40;  // copy does not count as source
  localparam logic [7:0] DEST_TOP_BITS = 8'h70;  // fifth dest byte: bits beyond 32
  localparam int         LAST_SHIFT    = 4;      // index of the fifth header byte
  localparam int         MAX_HDR_BYTES = 5;
  localparam int         NUM_ARGS      = 6;      // four offset bytes, two size bytes
  localparam int         SIZE_LO_ARG   = 4;
  localparam int         SIZE_HI_ARG   = 5;
  localparam logic       STATUS_OK     = 1'b0;
  localparam logic       STATUS_BAD    = 1'b1;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int CALM_REQUESTS   = 150;    // tail of the run where no new idle gaps or stall bursts start
  localparam int HOLD_AFTER      = 400;    // requests accepted before the long hold
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int WATCHDOG_NS     = 2_000_000;

  typedef struct packed {
    logic   status;
    count_t source_copied;
    count_t literal_bytes;
  } tally_t;

  // One request on the input channel, plus a hand-written tally where the
  // outcome is obvious; rows without one are checked against the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    tally_t     tally;
  } request_t;

  typedef struct {
    phase_t      phase;
    logic [2:0]  shift_pos;
    count_t      source_size;
    count_t      dest_size;
    logic [5:0]  pending_args;
    copy_size_t  copy_size;
    logic        copy_from_dest;
    logic [6:0]  literal_left;
    count_t      copied;
    count_t      added;
    out_count_t  out_len;
    byte_count_t seen;
  } parser_t;

  localparam tally_t NO_TALLY = '0;

  // Directed streams: each closes on a row whose tally is typed in.
  localparam request_t DIRECTED_TABLE [31] = '{
    // Short stream: one byte is below the minimum length.
    '{8'h00, 1'b1, 1'b1, '{STATUS_BAD, 32'd0, 32'd0}},
    // Source 0, dest 1; zero-length literal, then a one-byte literal.
    '{8'h00, 1'b0, 1'b0, NO_TALLY},
    '{8'h01, 1'b0, 1'b0, NO_TALLY},
    '{8'h00, 1'b0, 1'b0, NO_TALLY},
    '{8'h01, 1'b0, 1'b0, NO_TALLY},
    '{8'hAB, 1'b1, 1'b1, '{STATUS_OK, 32'd0, 32'd1}},
    // Dest 0x10000 over three header bytes; copy with no size bytes means 65536.
    '{8'h00, 1'b0, 1'b0, NO_TALLY},
    '{8'h80, 1'b0, 1'b0, NO_TALLY},
    '{8'h80, 1'b0, 1'b0, NO_TALLY},
    '{8'h04, 1'b0, 1'b0, NO_TALLY},
    '{8'h80, 1'b1, 1'b1, '{STATUS_OK, 32'd65536, 32'd0}},
    // Copy from the destination: one offset byte, low size 3, not counted.
    '{8'h05, 1'b0, 1'b0, NO_TALLY},
    '{8'h03, 1'b0, 1'b0, NO_TALLY},
    '{8'hD1, 1'b0, 1'b0, NO_TALLY},
    '{8'h77, 1'b0, 1'b0, NO_TALLY},
    '{8'h03, 1'b1, 1'b1, '{STATUS_OK, 32'd0, 32'd0}},
    // Source header still continuing on its fifth byte.
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b1, 1'b1, '{STATUS_BAD, 32'd0, 32'd0}},
    // Dest header whose fifth byte runs past 32 bits.
    '{8'h00, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'hFF, 1'b0, 1'b0, NO_TALLY},
    '{8'h7F, 1'b1, 1'b1, '{STATUS_BAD, 32'd0, 32'd0}},
    // Stream that ends inside a literal's data.
    '{8'h7F, 1'b0, 1'b0, NO_TALLY},
    '{8'h00, 1'b0, 1'b0, NO_TALLY},
    '{8'h03, 1'b0, 1'b0, NO_TALLY},
    '{8'hAA, 1'b1, 1'b1, '{STATUS_BAD, 32'd0, 32'd0}}
  };

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte  = 8'h00;
  logic       in_last_byte  = 1'b0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic       out_status;
  count_t     out_source_copied;
  count_t     out_literal_bytes;

  request_t stream_requests [$];   // everything the sender will offer, in order
  tally_t   expected_tallies [$];  // predicted results not yet seen on the output
  request_t cur_req       = '0;    // request currently on the input channel
  parser_t  parser;

  int   accepted_cnt  = 0;
  int   result_cnt    = 0;
  int   good_cnt      = 0;
  int   fail_cnt      = 0;
  logic calm_tail     = 1'b0;
  logic long_hold     = 1'b0;

  delta_copy_literal_counter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_source_copied (out_source_copied),
    .out_literal_bytes (out_literal_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stream parser: the expected behavior, one byte at a time.
  // ---------------------------------------------------------------------------

  function automatic void parser_reset();
    parser.phase          = PH_SOURCE_HDR;
    parser.shift_pos      = '0;
    parser.source_size    = '0;
    parser.dest_size      = '0;
    parser.pending_args   = '0;
    parser.copy_size      = '0;
    parser.copy_from_dest = 1'b0;
    parser.literal_left   = '0;
    parser.copied         = '0;
    parser.added          = '0;
    parser.out_len        = '0;
    parser.seen           = '0;
  endfunction

  function automatic count_t sat_add(count_t a, count_t b);
    logic [CNT_W:0] s;
    s = a + b;
    return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

  // The output length saturates at its own, wider limit.
  function automatic void grow_output(count_t n);
    logic [OUT_CNT_W:0] s;
    s = parser.out_len + n;
    parser.out_len = (s > OUT_COUNT_MAX) ? OUT_COUNT_MAX : s[OUT_CNT_W-1:0];
  endfunction

  // Close a copy: a size of zero stands for 64 KiB.
  function automatic void close_copy();
    count_t size;
    size = (parser.copy_size == '0) ? count_t'(COPY_ZERO_SIZE) : count_t'(parser.copy_size);
    if (!parser.copy_from_dest) parser.copied = sat_add(parser.copied, size);
    grow_output(size);
    parser.copy_size      = '0;
    parser.copy_from_dest = 1'b0;
    parser.pending_args   = '0;
    parser.phase          = PH_COMMAND;
  endfunction

  // Little-endian base-128 size byte; bits shifted past 32 are dropped.
  function automatic void take_header_byte(logic [7:0] b, logic is_dest);
    logic [63:0] part;
    part = 64'(b[6:0]) << (7 * parser.shift_pos);
    if (is_dest && parser.shift_pos >= LAST_SHIFT && (b & DEST_TOP_BITS) != 0) begin
      parser.phase = PH_BROKEN;
      return;
    end
    if (is_dest) parser.dest_size |= part[31:0];
    else parser.source_size |= part[31:0];
    if ((b & CONT_BIT) != 0) begin
      if (parser.shift_pos >= LAST_SHIFT) parser.phase = PH_BROKEN;
      else parser.shift_pos++;
    end else begin
      parser.shift_pos = '0;
      parser.phase     = is_dest ? PH_COMMAND : PH_DEST_HDR;
    end
  endfunction

  // Advance the parser by one byte; returns 1 with the tally on a final byte.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output tally_t res);
    int   k;
    logic bad;
    res = '0;
    if (parser.seen != BYTE_COUNT_MAX) parser.seen++;
    case (parser.phase)
      PH_SOURCE_HDR: take_header_byte(b, 1'b0);
      PH_DEST_HDR:   take_header_byte(b, 1'b1);
      PH_COMMAND: begin
        if ((b & COPY_BIT) != 0) begin
          parser.pending_args   = b[5:0];
          parser.copy_from_dest = (b & FROM_DEST_BIT) != 0;
          parser.copy_size      = '0;
          if (parser.pending_args == '0) close_copy();
          else parser.phase = PH_COPY_ARGS;
        end else begin
          parser.added = sat_add(parser.added, count_t'(b));
          grow_output(count_t'(b));
          parser.literal_left = b[6:0];
          if (parser.literal_left != 0) parser.phase = PH_LITERAL;
        end
      end
      PH_COPY_ARGS: begin
        // Argument bytes arrive in flag order: offsets first, then size.
        k = NUM_ARGS;
        for (int i = NUM_ARGS - 1; i >= 0; i--) begin
          if (parser.pending_args[i]) k = i;
        end
        if (k == SIZE_LO_ARG) parser.copy_size |= copy_size_t'(b);
        else if (k == SIZE_HI_ARG) parser.copy_size |= copy_size_t'(b) << 8;
        if (k < NUM_ARGS) parser.pending_args[k] = 1'b0;
        if (parser.pending_args == '0) close_copy();
      end
      PH_LITERAL: begin
        if (parser.literal_left != 0) parser.literal_left--;
        if (parser.literal_left == 0) parser.phase = PH_COMMAND;
      end
      default: parser.phase = PH_BROKEN;
    endcase
    if (!last) return 1'b0;
    bad = (parser.phase != PH_COMMAND) || (parser.seen < MIN_DELTA_BYTES) ||
          (parser.out_len != out_count_t'(parser.dest_size));
    res.status        = bad ? STATUS_BAD : STATUS_OK;
    res.source_copied = bad ? '0 : parser.copied;
    res.literal_bytes = bad ? '0 : parser.added;
    parser_reset();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------

  // Encode a size, minimal most of the time, otherwise padded up to 5 bytes.
  function automatic void encode_size(ref logic [7:0] q[$], input count_t v);
    int     n;
    count_t t;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    if ($urandom_range(0, 3) == 0) n = $urandom_range(n, MAX_HDR_BYTES);
    for (int i = 0; i < n; i++) begin
      q.push_back({(i != n - 1), 7'(v >> (7 * i))});
    end
  endfunction

  // Append one random stream. Mostly well-formed with random content; the rest
  // carries a size mismatch, an early cut, an over-long header or plain noise.
  function automatic void add_random_stream();
    logic [7:0]      stream_bytes [$];
    logic [7:0]      cmd_bytes [$];
    logic [7:0]      c;
    logic [7:0]      arg;
    logic [15:0]     sz;
    longint unsigned out_len;
    count_t          dest_hdr_len;
    int              kind;
    int              len;
    request_t        r;
    kind = $urandom_range(0, 99);
    if (kind >= 90 && kind < 95) begin
      // Noise: random bytes, whatever they parse to.
      len = $urandom_range(1, 10);
      repeat (len) stream_bytes.push_back(8'($urandom));
    end else if (kind >= 95) begin
      if ($urandom_range(0, 1) != 0) begin
        // Source header that never stops continuing.
        repeat (MAX_HDR_BYTES) stream_bytes.push_back(CONT_BIT | 8'($urandom));
      end else begin
        // Dest header with size bits beyond 32.
        encode_size(stream_bytes, count_t'($urandom));
        repeat (MAX_HDR_BYTES - 1) stream_bytes.push_back(CONT_BIT | 8'($urandom));
        stream_bytes.push_back(8'($urandom_range(8'h10, 8'hFF)));
      end
      repeat ($urandom_range(0, 6)) stream_bytes.push_back(8'($urandom));
    end else begin
      out_len = 0;
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 1) != 0) begin
          c  = COPY_BIT | 8'($urandom_range(0, 127));
          sz = '0;
          cmd_bytes.push_back(c);
          for (int i = 0; i < NUM_ARGS; i++) begin
            if (c[i]) begin
              arg = 8'($urandom);
              cmd_bytes.push_back(arg);
              if (i == SIZE_LO_ARG) sz[7:0] = arg;
              if (i == SIZE_HI_ARG) sz[15:8] = arg;
            end
          end
          out_len += (sz == 0) ? 64'h10000 : 64'(sz);
        end else begin
          // Mostly short literals, now and then up to the longest.
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
          cmd_bytes.push_back(8'(len));
          out_len += len;
          repeat (len) cmd_bytes.push_back(8'($urandom));
        end
      end
      dest_hdr_len = count_t'(out_len);
      if (kind >= 70 && kind < 80) dest_hdr_len ^= count_t'(1) << $urandom_range(0, 5);
      encode_size(stream_bytes, ($urandom_range(0, 1) != 0) ? count_t'($urandom) :
                                count_t'($urandom_range(0, 300)));
      encode_size(stream_bytes, dest_hdr_len);
      foreach (cmd_bytes[i]) stream_bytes.push_back(cmd_bytes[i]);
      // Early cut: drop the tail so the stream may end mid-command.
      if (kind >= 80) stream_bytes = stream_bytes[0:$urandom_range(0, stream_bytes.size() - 1)];
    end
    foreach (stream_bytes[i]) begin
      r      = '0;
      r.data = stream_bytes[i];
      r.last = (i == stream_bytes.size() - 1);
      stream_requests.push_back(r);
    end
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer requests in order, hold while stalled, idle in bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    int idx;
    int gap_left;
    int send_idle_pct;
    if (!rst_n) begin
      idx           = 0;
      gap_left      = 0;
      send_idle_pct = 10;
      in_valid     <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      // Anything offered and not stalled was taken at this edge.
      if (in_valid) idx++;
      if ($urandom_range(0, 127) == 0) send_idle_pct = pick_idle_pct();
      if (idx >= stream_requests.size() - CALM_REQUESTS) calm_tail <= 1'b1;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idx < stream_requests.size()) begin
        if (idx < stream_requests.size() - CALM_REQUESTS &&
            $urandom_range(0, 99) < send_idle_pct) begin
          gap_left  = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          cur_req      <= stream_requests[idx];
          in_data_byte <= stream_requests[idx].data;
          in_last_byte <= stream_requests[idx].last;
          in_valid     <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, plus one long hold to back up the block.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    int stall_left;
    int recv_idle_pct;
    if (!rst_n) begin
      stall_left    = 0;
      recv_idle_pct = 10;
      out_stall    <= 1'b0;
    end else begin
      if ($urandom_range(0, 127) == 0) recv_idle_pct = pick_idle_pct();
      if (stall_left > 0) stall_left--;
      else if (!calm_tail && $urandom_range(0, 99) < recv_idle_pct)
        stall_left = $urandom_range(1, 4);
      out_stall <= long_hold || (stall_left > 0);
    end
  end

  // Hold off the result side long enough that a second final byte arrives
  // while a result is still waiting, so the input must stall.
  initial begin : hold_off
    while (accepted_cnt < HOLD_AFTER) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    tally_t res;
    tally_t got;
    tally_t want;
    if (!rst_n) begin
      parser_reset();
    end else begin
      if (in_valid && !in_stall) begin
        // Rows with a typed-in tally use it; the parser still advances.
        if (parse_byte(in_data_byte, in_last_byte, res))
          expected_tallies.push_back(cur_req.typed ? cur_req.tally : res);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        got = '{out_status, out_source_copied, out_literal_bytes};
        result_cnt++;
        if (expected_tallies.size() == 0) begin
          $error("result with none expected: status %0d source_copied %0d literal_bytes %0d",
                 got.status, got.source_copied, got.literal_bytes);
          fail_cnt++;
        end else begin
          want = expected_tallies.pop_front();
          if (got.status == STATUS_OK) good_cnt++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
          end
          if (got.source_copied !== want.source_copied) begin
            $error("source_copied: expected %0d, got %0d", want.source_copied,
                   got.source_copied);
            fail_cnt++;
          end
          if (got.literal_bytes !== want.literal_bytes) begin
            $error("literal_bytes: expected %0d, got %0d", want.literal_bytes,
                   got.literal_bytes);
            fail_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control: build the stimulus, reset once, drain, report.
  // ---------------------------------------------------------------------------
  initial begin : run_ctl
    foreach (DIRECTED_TABLE[i]) stream_requests.push_back(DIRECTED_TABLE[i]);
    while (stream_requests.size() < $size(DIRECTED_TABLE) + RANDOM_REQUESTS)
      add_random_stream();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the active edge so the counters have settled.
    do @(negedge clk);
    while (accepted_cnt < stream_requests.size() || expected_tallies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d delta bytes in directed and random streams; %0d results checked,",
             accepted_cnt, result_cnt);
    $display("%0d of them valid deltas, the rest malformed, cut short or mismatched.",
             good_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dclc_pkg.sv
rtl/delta_copy_literal_counter.sv
rtl/dclc_checker.sv
test/delta_copy_literal_counter_tb.sv
